>>> rtl/mdc_pkg.sv
`default_nettype none

package mdc_pkg;

    localparam int NUM_AXES     = 3;
    localparam int WORD_W       = 16;
    localparam int RAW_W        = 24;
    localparam int FLD_W        = 32;
    localparam int SCALE_W      = 32;
    localparam int PROD_W       = RAW_W + SCALE_W + 1;
    localparam int DIF_W        = FLD_W + 1;
    localparam int COEF_W       = 16;
    localparam int ROW_W        = NUM_AXES * COEF_W;
    localparam int MPROD_W      = COEF_W + DIF_W;
    localparam int ACC_W        = MPROD_W + 2;
    localparam int SAT_W        = PROD_W;
    localparam int FIELD_SHIFT  = 16;
    localparam int MATRIX_SHIFT = 12;
    localparam int CFG_DATA_W   = ROW_W;
    localparam int CFG_IDX_W    = 3;

    localparam logic signed [PROD_W-1:0] ROUND_FLD = PROD_W'(1) << (FIELD_SHIFT - 1);
    localparam logic signed [ACC_W-1:0]  ROUND_CAL = ACC_W'(1) << (MATRIX_SHIFT - 1);

    localparam logic [FLD_W-1:0] FLD_MAX = {1'b0, {(FLD_W - 1){1'b1}}};
    localparam logic [FLD_W-1:0] FLD_MIN = {1'b1, {(FLD_W - 1){1'b0}}};

    // Identity soft-iron matrix, one Q4.12 unit on the diagonal.
    localparam logic [ROW_W-1:0] ROW0_RESET = ROW_W'(48'h0000_0000_1000);
    localparam logic [ROW_W-1:0] ROW1_RESET = ROW_W'(48'h0000_1000_0000);
    localparam logic [ROW_W-1:0] ROW2_RESET = ROW_W'(48'h1000_0000_0000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LSB_SCALE   = 3'd0,
        REG_BIAS_X      = 3'd1,
        REG_BIAS_Y      = 3'd2,
        REG_BIAS_Z      = 3'd3,
        REG_MATRIX_ROW0 = 3'd4,
        REG_MATRIX_ROW1 = 3'd5,
        REG_MATRIX_ROW2 = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [WORD_W-1:0] word0;
        logic [WORD_W-1:0] word1;
        logic [WORD_W-1:0] word2;
        logic [WORD_W-1:0] word3;
        logic [WORD_W-1:0] word4;
    } in_t;

    typedef struct packed {
        logic signed [RAW_W-1:0] raw_x;
        logic signed [RAW_W-1:0] raw_y;
        logic signed [RAW_W-1:0] raw_z;
        logic signed [FLD_W-1:0] field_x;
        logic signed [FLD_W-1:0] field_y;
        logic signed [FLD_W-1:0] field_z;
        logic signed [FLD_W-1:0] cal_x;
        logic signed [FLD_W-1:0] cal_y;
        logic signed [FLD_W-1:0] cal_z;
    } out_t;

    typedef struct packed {
        logic [SCALE_W-1:0]               lsb_scale;
        logic [NUM_AXES-1:0][FLD_W-1:0]   bias;
        logic [NUM_AXES-1:0][ROW_W-1:0]   row;
    } cfg_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][RAW_W-1:0]  raw;
        logic [NUM_AXES-1:0][PROD_W-1:0] prod;
    } scl_item_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][RAW_W-1:0] raw;
        logic [NUM_AXES-1:0][FLD_W-1:0] fld;
    } fld_item_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][RAW_W-1:0] raw;
        logic [NUM_AXES-1:0][FLD_W-1:0] fld;
        logic [NUM_AXES-1:0][DIF_W-1:0] dif;
    } dif_item_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][RAW_W-1:0]                 raw;
        logic [NUM_AXES-1:0][FLD_W-1:0]                 fld;
        logic [NUM_AXES-1:0][NUM_AXES-1:0][MPROD_W-1:0] prod;
    } mac_item_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][RAW_W-1:0] raw;
        logic [NUM_AXES-1:0][FLD_W-1:0] fld;
        logic [NUM_AXES-1:0][ACC_W-1:0] acc;
    } acc_item_t;

    // Clamp a sign-extended value to the signed 32-bit range.
    function automatic logic [FLD_W-1:0] sat_fld(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-FLD_W:0] top;
        top = v[SAT_W-1:FLD_W-1];
        if (top == '0 || top == '1)
        begin
            return v[FLD_W-1:0];
        end
        else if (v[SAT_W-1])
        begin
            return FLD_MIN;
        end
        else
        begin
            return FLD_MAX;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/magnetometer_decode_calibrate_unit.sv
// Magnetometer burst decoder with hard-iron and soft-iron calibration. Each
// input transaction carries one five-word sensor burst; the block unpacks the
// three 24-bit axis counts, scales them to Q15.16 gauss with the lsb_scale
// register, subtracts the per-axis bias and applies the 3x3 Q4.12 soft-iron
// matrix, returning one output transaction with the raw, scaled and
// calibrated values of all three axes. Rounding is to nearest with ties
// toward plus infinity, and the field and calibrated values clamp to the
// signed 32-bit range. The datapath is a six-stage pipeline (scale multiply,
// round and clamp, bias subtract, matrix multiply, row sum, final round and
// clamp), so a burst can be accepted on every clock cycle unless a stall has
// backed up to the input; the last stage doubles as the output register,
// and every stage advances on its own, so a stalled output only holds back
// the stages that are full. Configuration writes through cfg_write take
// effect on the next cycle and must only be issued while the pipeline is
// empty. After reset the scale and biases are zero and the matrix is the
// identity.

`default_nettype none

module magnetometer_decode_calibrate_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [mdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mdc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire mdc_pkg::in_t                   in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output mdc_pkg::out_t                       out_data
);

    // Register file shared by both halves of the datapath.
    mdc_pkg::cfg_t      cfg;

    // Transaction between the scaling half and the calibration half.
    logic               fld_valid;
    logic               fld_ready;
    mdc_pkg::fld_item_t fld_data;

    mdc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stages one and two: unpack, scale, round and clamp.
    mdc_field u_field (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .fld_valid (fld_valid),
        .fld_ready (fld_ready),
        .fld_data  (fld_data)
    );

    // Stages three to six: bias removal, soft-iron matrix, output register.
    mdc_soft_iron u_soft_iron (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fld_valid (fld_valid),
        .fld_ready (fld_ready),
        .fld_data  (fld_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    // When the consumer takes results, no stage may hold back the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled although the output side is ready");

    // A zero count scales to a zero field whatever the scale register holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.raw_x == '0) |-> (out_data.field_x == '0))
        else $error("x field does not travel with its raw count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.raw_z == '0) |-> (out_data.field_z == '0))
        else $error("z field does not travel with its raw count");
`endif

endmodule

`default_nettype wire

>>> rtl/mdc_cfg.sv
`default_nettype none

module mdc_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [mdc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mdc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output mdc_pkg::cfg_t                         cfg
);

    mdc_pkg::cfg_t cfg_reg;
    mdc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                mdc_pkg::REG_LSB_SCALE:
                    cfg_next.lsb_scale = cfg_data[mdc_pkg::SCALE_W-1:0];
                mdc_pkg::REG_BIAS_X:
                    cfg_next.bias[0] = cfg_data[mdc_pkg::FLD_W-1:0];
                mdc_pkg::REG_BIAS_Y:
                    cfg_next.bias[1] = cfg_data[mdc_pkg::FLD_W-1:0];
                mdc_pkg::REG_BIAS_Z:
                    cfg_next.bias[2] = cfg_data[mdc_pkg::FLD_W-1:0];
                mdc_pkg::REG_MATRIX_ROW0:
                    cfg_next.row[0] = cfg_data[mdc_pkg::ROW_W-1:0];
                mdc_pkg::REG_MATRIX_ROW1:
                    cfg_next.row[1] = cfg_data[mdc_pkg::ROW_W-1:0];
                mdc_pkg::REG_MATRIX_ROW2:
                    cfg_next.row[2] = cfg_data[mdc_pkg::ROW_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lsb_scale <= '0;
            cfg_reg.bias      <= '0;
            cfg_reg.row[0]    <= mdc_pkg::ROW0_RESET;
            cfg_reg.row[1]    <= mdc_pkg::ROW1_RESET;
            cfg_reg.row[2]    <= mdc_pkg::ROW2_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/mdc_field.sv
`default_nettype none

// Burst unpack and scaling: stage 1 multiplies each count by the scale,
// stage 2 rounds, shifts and clamps to Q15.16.
module mdc_field (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mdc_pkg::cfg_t      cfg,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire mdc_pkg::in_t       in_data,
    output logic                    fld_valid,
    input  wire logic               fld_ready,
    output mdc_pkg::fld_item_t      fld_data
);

    logic                  st1_valid_reg;
    mdc_pkg::scl_item_t    st1_reg;
    mdc_pkg::scl_item_t    st1_next;
    logic                  st1_ready;

    logic                  st2_valid_reg;
    mdc_pkg::fld_item_t    st2_reg;
    mdc_pkg::fld_item_t    st2_next;
    logic                  st2_ready;

    logic signed [mdc_pkg::PROD_W-1:0] prod_s  [mdc_pkg::NUM_AXES];
    logic signed [mdc_pkg::PROD_W-1:0] rnd_s   [mdc_pkg::NUM_AXES];
    logic signed [mdc_pkg::PROD_W-1:0] shift_s [mdc_pkg::NUM_AXES];

    assign st2_ready = !st2_valid_reg || fld_ready;
    assign st1_ready = !st1_valid_reg || st2_ready;
    assign in_ready  = st1_ready;

    always_comb
    begin
        st1_next.raw[0] = {in_data.word0[7:0], in_data.word1};
        st1_next.raw[1] = {in_data.word2, in_data.word3[15:8]};
        st1_next.raw[2] = {in_data.word3[7:0], in_data.word4};
        for (int i = 0; i < mdc_pkg::NUM_AXES; i++)
        begin
            prod_s[i] = $signed(st1_next.raw[i]) * $signed({1'b0, cfg.lsb_scale});
            st1_next.prod[i] = prod_s[i];
        end
    end

    always_comb
    begin
        st2_next.raw = st1_reg.raw;
        for (int i = 0; i < mdc_pkg::NUM_AXES; i++)
        begin
            rnd_s[i]   = $signed(st1_reg.prod[i]) + mdc_pkg::ROUND_FLD;
            shift_s[i] = rnd_s[i] >>> mdc_pkg::FIELD_SHIFT;
            st2_next.fld[i] = mdc_pkg::sat_fld(shift_s[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end
        else
        begin
            if (st1_ready)
            begin
                st1_valid_reg <= in_valid;
            end
            if (st2_ready)
            begin
                st2_valid_reg <= st1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && st1_ready)
        begin
            st1_reg <= st1_next;
        end
        if (st1_valid_reg && st2_ready)
        begin
            st2_reg <= st2_next;
        end
    end

    assign fld_valid = st2_valid_reg;
    assign fld_data  = st2_reg;

endmodule

`default_nettype wire

>>> rtl/mdc_soft_iron.sv
`default_nettype none

// Bias removal and 3x3 soft-iron matrix: stage 3 subtracts the bias,
// stage 4 forms the nine products, stage 5 sums each row, and stage 6
// rounds, clamps and holds the finished result.
module mdc_soft_iron (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mdc_pkg::cfg_t      cfg,
    input  wire logic               fld_valid,
    output logic                    fld_ready,
    input  wire mdc_pkg::fld_item_t fld_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mdc_pkg::out_t           out_data
);

    logic               st3_valid_reg;
    mdc_pkg::dif_item_t st3_reg;
    mdc_pkg::dif_item_t st3_next;
    logic               st3_ready;

    logic               st4_valid_reg;
    mdc_pkg::mac_item_t st4_reg;
    mdc_pkg::mac_item_t st4_next;
    logic               st4_ready;

    logic               st5_valid_reg;
    mdc_pkg::acc_item_t st5_reg;
    mdc_pkg::acc_item_t st5_next;
    logic               st5_ready;

    logic               st6_valid_reg;
    mdc_pkg::out_t      st6_reg;
    mdc_pkg::out_t      st6_next;
    logic               st6_ready;

    logic signed [mdc_pkg::DIF_W-1:0]   dif_s  [mdc_pkg::NUM_AXES];
    logic signed [mdc_pkg::COEF_W-1:0]  coef_s [mdc_pkg::NUM_AXES][mdc_pkg::NUM_AXES];
    logic signed [mdc_pkg::MPROD_W-1:0] mp_s   [mdc_pkg::NUM_AXES][mdc_pkg::NUM_AXES];
    logic signed [mdc_pkg::ACC_W-1:0]   acc_s  [mdc_pkg::NUM_AXES];
    logic signed [mdc_pkg::ACC_W-1:0]   sh_s   [mdc_pkg::NUM_AXES];
    logic        [mdc_pkg::FLD_W-1:0]   cal_s  [mdc_pkg::NUM_AXES];

    assign st6_ready = !st6_valid_reg || out_ready;
    assign st5_ready = !st5_valid_reg || st6_ready;
    assign st4_ready = !st4_valid_reg || st5_ready;
    assign st3_ready = !st3_valid_reg || st4_ready;
    assign fld_ready = st3_ready;

    // The difference is kept exact at one bit wider than the field.
    always_comb
    begin
        st3_next.raw = fld_data.raw;
        st3_next.fld = fld_data.fld;
        for (int i = 0; i < mdc_pkg::NUM_AXES; i++)
        begin
            dif_s[i] = mdc_pkg::DIF_W'($signed(fld_data.fld[i]))
                     - mdc_pkg::DIF_W'($signed(cfg.bias[i]));
            st3_next.dif[i] = dif_s[i];
        end
    end

    always_comb
    begin
        st4_next.raw = st3_reg.raw;
        st4_next.fld = st3_reg.fld;
        for (int i = 0; i < mdc_pkg::NUM_AXES; i++)
        begin
            for (int j = 0; j < mdc_pkg::NUM_AXES; j++)
            begin
                coef_s[i][j] = $signed(cfg.row[i][mdc_pkg::COEF_W*j +: mdc_pkg::COEF_W]);
                mp_s[i][j]   = coef_s[i][j] * $signed(st3_reg.dif[j]);
                st4_next.prod[i][j] = mp_s[i][j];
            end
        end
    end

    always_comb
    begin
        st5_next.raw = st4_reg.raw;
        st5_next.fld = st4_reg.fld;
        for (int i = 0; i < mdc_pkg::NUM_AXES; i++)
        begin
            acc_s[i] = mdc_pkg::ACC_W'($signed(st4_reg.prod[i][0]))
                     + mdc_pkg::ACC_W'($signed(st4_reg.prod[i][1]))
                     + mdc_pkg::ACC_W'($signed(st4_reg.prod[i][2]))
                     + mdc_pkg::ROUND_CAL;
            st5_next.acc[i] = acc_s[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < mdc_pkg::NUM_AXES; i++)
        begin
            sh_s[i]  = $signed(st5_reg.acc[i]) >>> mdc_pkg::MATRIX_SHIFT;
            cal_s[i] = mdc_pkg::sat_fld(mdc_pkg::SAT_W'(sh_s[i]));
        end
        st6_next.raw_x   = $signed(st5_reg.raw[0]);
        st6_next.raw_y   = $signed(st5_reg.raw[1]);
        st6_next.raw_z   = $signed(st5_reg.raw[2]);
        st6_next.field_x = $signed(st5_reg.fld[0]);
        st6_next.field_y = $signed(st5_reg.fld[1]);
        st6_next.field_z = $signed(st5_reg.fld[2]);
        st6_next.cal_x   = $signed(cal_s[0]);
        st6_next.cal_y   = $signed(cal_s[1]);
        st6_next.cal_z   = $signed(cal_s[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            st5_valid_reg <= 1'b0;
            st6_valid_reg <= 1'b0;
        end
        else
        begin
            if (st3_ready)
            begin
                st3_valid_reg <= fld_valid;
            end
            if (st4_ready)
            begin
                st4_valid_reg <= st3_valid_reg;
            end
            if (st5_ready)
            begin
                st5_valid_reg <= st4_valid_reg;
            end
            if (st6_ready)
            begin
                st6_valid_reg <= st5_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fld_valid && st3_ready)
        begin
            st3_reg <= st3_next;
        end
        if (st3_valid_reg && st4_ready)
        begin
            st4_reg <= st4_next;
        end
        if (st4_valid_reg && st5_ready)
        begin
            st5_reg <= st5_next;
        end
        if (st5_valid_reg && st6_ready)
        begin
            st6_reg <= st6_next;
        end
    end

    assign out_valid = st6_valid_reg;
    assign out_data  = st6_reg;

endmodule

`default_nettype wire
